// ----- hdl/sorted_index_key_lookup_macros.svh -----
// Assertion macros shared by the sorted index lookup RTL.
// Included inside module bodies; needs clk and rst_n in scope.
`ifndef SORTED_INDEX_KEY_LOOKUP_MACROS_SVH
`define SORTED_INDEX_KEY_LOOKUP_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define SIKL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Stalled word keeps valid and payload until it is accepted
`define SIKL_HOLD(label, vld, stl, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && (stl)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

// ----- hdl/sikl_pkg.sv -----
// Package for the sorted index key lookup block.
// Holds address widths, register indexes and offset mode codes; no dependencies.
package sikl_pkg;

  localparam int BA_W = 28;   // byte address width inside the image

  typedef logic [BA_W-1:0] byte_addr_t;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_BYTES  = 3'd0;
  localparam logic [2:0] REG_SIZE_BYTES = 3'd1;
  localparam logic [2:0] REG_OFF_BYTES  = 3'd2;
  localparam logic [2:0] REG_BLK_KB     = 3'd3;
  localparam logic [2:0] REG_NUM_BLOCKS = 3'd4;
  localparam logic [2:0] REG_EPB        = 3'd5;
  localparam logic [2:0] REG_ELB        = 3'd6;
  localparam logic [2:0] REG_ARCHIVE    = 3'd7;

  // offset field layouts
  localparam logic [2:0] OB_FILE  = 3'd0;
  localparam logic [2:0] OB_SHORT = 3'd2;
  localparam logic [2:0] OB_GROUP = 3'd6;

  // input function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

endpackage

// ----- hdl/sorted_index_key_lookup.sv -----
// Sorted index key lookup: a write word is stored in the image memory.
// A lookup runs two lower-bound binary searches (per-block key table, then the
// chosen block's entries) and an exact-match check, one image byte at a time
// through a single memory read port and a byte comparator. A probe compares up
// to k bytes, k being the compare length (key_bytes, at most 16), and ends early
// when a byte mismatch decides it. A hit then reads the four size bytes and f
// offset bytes (f is 0, 2, 6, else 4 by offset layout). The input stalls while a
// lookup runs and while a finished result waits for the output slot; one finished
// result may wait at the output.
// Depends on sikl_pkg and sorted_index_key_lookup_macros.svh.
module sorted_index_key_lookup #(
  parameter int IMAGE_WORDS   = 32768,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [14:0]        in_word_addr,
  input  logic [63:0]        in_write_data,
  input  logic [63:0]        in_key_high,
  input  logic [63:0]        in_key_low,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic signed [31:0] out_entry_offset,
  output logic signed [31:0] out_entry_size,
  output logic signed [15:0] out_archive_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sikl_pkg::*;
  `include "sorted_index_key_lookup_macros.svh"

  localparam int AW = $clog2(IMAGE_WORDS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOC   = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_CRD   = 4'd3;
  localparam logic [3:0] S_CEV   = 4'd4;
  localparam logic [3:0] S_BLK   = 4'd5;
  localparam logic [3:0] S_EADDR = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FEV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // configuration registers
  logic [4:0]  kb_r;
  logic [3:0]  sb_r;
  logic [2:0]  ob_r;
  logic [7:0]  bkb_r;
  logic [8:0]  nb_r;
  logic [12:0] epb_r, elb_r;
  logic [15:0] arc_cfg_r;

  // sequencer state
  logic [3:0]   state_r;
  logic [1:0]   phase_r;      // 0 block search, 1 entry search, 2 exact check
  logic [127:0] key_r;
  logic [12:0]  lo_r, n_r, mid_r, half_r, count_r;
  logic [5:0]   stride_r;
  byte_addr_t   base_r, p_r, ba_r;
  logic [4:0]   i_r;
  logic         fld_r;
  logic [2:0]   cnt_r;
  logic [47:0]  acc_r;
  logic [31:0]  size_r;
  logic         hit_r;

  logic         out_valid_r, out_found_r;
  logic [31:0]  out_off_r, out_size_r;
  logic [15:0]  out_arc_r;

  logic [63:0]  mem [IMAGE_WORDS];
  logic [63:0]  rdata_r;
  logic         oob_r;

  logic [4:0]   cmp_len;
  logic [17:0]  bsize;
  logic [7:0]   rbyte, kbyte;
  logic [31:0]  wa_ext;
  logic [24:0]  word_idx;
  logic         take_in;

  assign cmp_len  = (kb_r > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : kb_r;
  assign bsize    = {bkb_r, 10'd0};
  assign word_idx = ba_r[BA_W-1:3];
  assign wa_ext   = {17'd0, in_word_addr};
  assign rbyte    = oob_r ? 8'd0 : rdata_r[(63 - 8*int'(ba_r[2:0])) -: 8];
  assign kbyte    = key_r[(127 - 8*int'(i_r[3:0])) -: 8];
  assign take_in  = in_valid && !in_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_entry_offset   = out_off_r;
  assign out_entry_size     = out_size_r;
  assign out_archive_number = out_arc_r;

  // image memory: write on a write word, read every cycle at the byte pointer
  always_ff @(posedge clk) begin
    if (take_in && in_func == FUNC_WRITE && wa_ext < 32'(IMAGE_WORDS)) begin
      mem[wa_ext[AW-1:0]] <= in_write_data;
    end
    rdata_r <= mem[ba_r[AW+2:3]];
    oob_r   <= (32'(word_idx) >= 32'(IMAGE_WORDS));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r <= 5'd9; sb_r <= 4'd4; ob_r <= 3'd4; bkb_r <= 8'd4;
      nb_r <= 9'd1; epb_r <= 13'd1; elb_r <= 13'd1; arc_cfg_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_BYTES:  kb_r      <= cfg_data[4:0];
        REG_SIZE_BYTES: sb_r      <= cfg_data[3:0];
        REG_OFF_BYTES:  ob_r      <= cfg_data[2:0];
        REG_BLK_KB:     bkb_r     <= cfg_data[7:0];
        REG_NUM_BLOCKS: nb_r      <= cfg_data[8:0];
        REG_EPB:        epb_r     <= cfg_data[12:0];
        REG_ELB:        elb_r     <= cfg_data[12:0];
        REG_ARCHIVE:    arc_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 2'd0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (take_in && in_func == FUNC_LOOKUP) begin
            key_r   <= {in_key_high, in_key_low};
            state_r <= S_TOC;
          end
        end
        // start the block key search at the table after the last block
        S_TOC: begin
          base_r   <= BA_W'(nb_r) * BA_W'(bsize);
          stride_r <= 6'(kb_r);
          lo_r     <= 13'd0;
          n_r      <= 13'(nb_r);
          count_r  <= 13'(nb_r);
          phase_r  <= 2'd0;
          state_r  <= S_PROBE;
        end
        S_PROBE: begin
          if (n_r == 13'd0) begin
            state_r <= (phase_r == 2'd0) ? S_BLK : S_EADDR;
          end else begin
            half_r  <= n_r >> 1;
            mid_r   <= lo_r + (n_r >> 1);
            p_r     <= base_r + BA_W'(lo_r + (n_r >> 1)) * BA_W'(stride_r);
            ba_r    <= base_r + BA_W'(lo_r + (n_r >> 1)) * BA_W'(stride_r);
            i_r     <= 5'd0;
            if (cmp_len == 5'd0) begin
              n_r <= n_r >> 1;
            end else begin
              state_r <= S_CRD;
            end
          end
        end
        S_CRD: state_r <= S_CEV;
        // compare one key byte; a mismatch decides the probe
        S_CEV: begin
          if (rbyte != kbyte) begin
            if (phase_r == 2'd2) begin
              hit_r   <= 1'b0;
              state_r <= S_DONE;
            end else begin
              if (rbyte < kbyte) begin
                lo_r <= mid_r + 13'd1;
                n_r  <= n_r - half_r - 13'd1;
              end else begin
                n_r <= half_r;
              end
              state_r <= S_PROBE;
            end
          end else if (i_r + 5'd1 == cmp_len) begin
            if (phase_r == 2'd2) begin
              ba_r    <= p_r + BA_W'(kb_r);
              fld_r   <= 1'b0;
              cnt_r   <= 3'd4;
              acc_r   <= 48'd0;
              state_r <= S_FRD;
            end else begin
              n_r     <= half_r;
              state_r <= S_PROBE;
            end
          end else begin
            i_r     <= i_r + 5'd1;
            ba_r    <= ba_r + BA_W'(1);
            state_r <= S_CRD;
          end
        end
        // block chosen: set up the entry search
        S_BLK: begin
          if (lo_r >= 13'(nb_r)) begin
            hit_r   <= 1'b0;
            state_r <= S_DONE;
          end else begin
            base_r   <= BA_W'(lo_r[8:0]) * BA_W'(bsize);
            stride_r <= 6'(kb_r) + 6'(sb_r) + 6'(ob_r);
            n_r      <= (lo_r + 13'd1 < 13'(nb_r)) ? epb_r : elb_r;
            count_r  <= (lo_r + 13'd1 < 13'(nb_r)) ? epb_r : elb_r;
            lo_r     <= 13'd0;
            phase_r  <= 2'd1;
            state_r  <= S_PROBE;
          end
        end
        // entry chosen: check for an exact match
        S_EADDR: begin
          if (lo_r >= count_r) begin
            hit_r   <= 1'b0;
            state_r <= S_DONE;
          end else begin
            p_r     <= base_r + BA_W'(lo_r) * BA_W'(stride_r);
            i_r     <= 5'd0;
            phase_r <= 2'd2;
            if (cmp_len == 5'd0) begin
              ba_r    <= base_r + BA_W'(lo_r) * BA_W'(stride_r) + BA_W'(kb_r);
              fld_r   <= 1'b0;
              cnt_r   <= 3'd4;
              acc_r   <= 48'd0;
              state_r <= S_FRD;
            end else begin
              ba_r    <= base_r + BA_W'(lo_r) * BA_W'(stride_r);
              state_r <= S_CRD;
            end
          end
        end
        S_FRD: state_r <= S_FEV;
        // gather field bytes big-endian
        S_FEV: begin
          if (cnt_r == 3'd1 && !fld_r) begin
            size_r <= {acc_r[23:0], rbyte};
            acc_r  <= 48'd0;
            fld_r  <= 1'b1;
            ba_r   <= p_r + BA_W'(kb_r) + BA_W'(sb_r);
            hit_r  <= 1'b1;
            case (ob_r)
              OB_FILE:  begin cnt_r <= 3'd0; state_r <= S_DONE; end
              OB_SHORT: begin cnt_r <= 3'd2; state_r <= S_FRD; end
              OB_GROUP: begin cnt_r <= 3'd6; state_r <= S_FRD; end
              default:  begin cnt_r <= 3'd4; state_r <= S_FRD; end
            endcase
          end else begin
            acc_r   <= {acc_r[39:0], rbyte};
            ba_r    <= ba_r + BA_W'(1);
            cnt_r   <= cnt_r - 3'd1;
            state_r <= (cnt_r == 3'd1) ? S_DONE : S_FRD;
          end
        end
        // hold the result until the output slot is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_found_r <= hit_r;
            if (!hit_r) begin
              out_off_r  <= '1;
              out_size_r <= '1;
              out_arc_r  <= '1;
            end else begin
              out_size_r <= size_r;
              case (ob_r)
                OB_FILE:  begin out_off_r <= '1; out_arc_r <= arc_cfg_r; end
                OB_SHORT: begin out_off_r <= {16'd0, acc_r[15:0]}; out_arc_r <= arc_cfg_r; end
                OB_GROUP: begin out_off_r <= acc_r[31:0]; out_arc_r <= acc_r[47:32]; end
                default:  begin out_off_r <= acc_r[31:0]; out_arc_r <= arc_cfg_r; end
              endcase
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SIKL_ASSERT(a_miss_all_ones, (out_valid && !out_found) |-> (out_entry_size == -32'sd1 && out_archive_number == -16'sd1 && out_entry_offset == -32'sd1), "miss result not all ones")
  `SIKL_ASSERT(a_n_in_range, (state_r == S_PROBE) |-> (n_r <= count_r && lo_r + n_r <= count_r), "search window outside range")
  `SIKL_ASSERT(a_idx_in_key, (state_r == S_CEV) |-> (i_r < cmp_len), "key byte index past compare length")
  `SIKL_HOLD(a_out_hold, out_valid, out_stall, {out_found, out_entry_offset, out_entry_size, out_archive_number}, "stalled result word changed")

endmodule
